// ===== rtl/entity_overlap_query_defines.svh =====
// ----------------------------------------------------------------------------
// entity_overlap_query_defines
// Assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ENTITY_OVERLAP_QUERY_DEFINES_SVH
`define ENTITY_OVERLAP_QUERY_DEFINES_SVH

// Same-cycle implication, held off while in reset.
`define EOQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while in reset.
`define EOQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/eoq_pkg.sv =====
// ----------------------------------------------------------------------------
// eoq_pkg
// Types and constants of the entity overlap query block.
// ----------------------------------------------------------------------------
package eoq_pkg;

  localparam int FRAC_BITS  = 12;
  localparam int Z_BAND_LO  = -126;
  localparam int Z_BAND_HI  = 127;

  // request function codes
  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_QUERY = 2'd1,
    FUNC_READ  = 2'd2
  } eoq_func_e;

  // configuration register indexes
  typedef enum logic {
    REG_ENTITY_COUNT = 1'b0,
    REG_PLAYER_INDEX = 1'b1
  } eoq_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } eoq_state_e;

  typedef struct packed {
    logic [1:0]         func;
    logic [4:0]         index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0]        radius;
    logic               active;
    logic               no_mark;
    logic               passable;
  } eoq_req_t;

  typedef struct packed {
    logic found;
    logic mark;
  } eoq_res_t;

  // one table entry, held in a cell
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [15:0] radius;
    logic        active;
    logic        no_mark;
    logic        passable;
  } eoq_entry_t;

  // query operands latched at request time
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [15:0] self_radius;
  } eoq_query_t;

  // overlap test outcome
  typedef struct packed {
    logic hit;
    logic no_mark;
    logic passable;
  } eoq_hit_t;

endpackage

// ===== rtl/eoq_cell.sv =====
// ----------------------------------------------------------------------------
// eoq_cell
// One entry of the entity ring: loads on write, passes to its neighbor on shift.
// ----------------------------------------------------------------------------
module eoq_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  eoq_pkg::eoq_entry_t load_data_i,
  input  logic               shift_i,
  input  eoq_pkg::eoq_entry_t shift_data_i,
  output eoq_pkg::eoq_entry_t data_o
);
  import eoq_pkg::*;

  eoq_entry_t ent_q, ent_d;
  logic       active_q;

  // next entry value
  always_comb begin
    ent_d = ent_q;
    if (load_i) begin
      ent_d = load_data_i;
    end else if (shift_i) begin
      ent_d = shift_data_i;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  // active flag clears on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= ent_d.active;
    end
  end

  always_comb begin
    data_o        = ent_q;
    data_o.active = active_q;
  end

endmodule

// ===== rtl/eoq_test.sv =====
// ----------------------------------------------------------------------------
// eoq_test
// Three-stage overlap test on the entry leaving the head of the ring.
// ----------------------------------------------------------------------------
module eoq_test #(
  parameter int IDX_W = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [IDX_W-1:0]     idx_i,
  input  eoq_pkg::eoq_entry_t  ent_i,
  input  eoq_pkg::eoq_query_t  qry_i,
  output eoq_pkg::eoq_hit_t    hit_o,
  output logic [IDX_W-1:0]     hit_idx_o
);
  import eoq_pkg::*;

  localparam logic signed [33:0] BAND_LO = 34'(Z_BAND_LO);
  localparam logic signed [33:0] BAND_HI = 34'(Z_BAND_HI);

  logic signed [33:0] dz;
  logic signed [32:0] dx_full, dy_full;
  logic               band_ok;
  logic [16:0]        r_sum;

  logic               a_valid_q;
  logic signed [20:0] a_dx_q, a_dy_q;
  logic [15:0]        a_r_q;
  logic               a_nm_q, a_pass_q;
  logic [IDX_W-1:0]   a_idx_q;

  logic signed [41:0] dx2, dy2;
  logic [31:0]        r2;

  logic               b_valid_q;
  logic [40:0]        b_dx2_q, b_dy2_q;
  logic [31:0]        b_r2_q;
  logic               b_nm_q, b_pass_q;
  logic [IDX_W-1:0]   b_idx_q;

  // stage A: z band, floored xy differences, mean radius
  always_comb begin
    dz = $signed({{14{ent_i.z[31]}}, ent_i.z[31:FRAC_BITS]})
       - $signed({{2{qry_i.z[31]}}, qry_i.z});
    band_ok = (dz >= BAND_LO) && (dz <= BAND_HI);
    dx_full = $signed({ent_i.x[31], ent_i.x}) - $signed({qry_i.x[31], qry_i.x});
    dy_full = $signed({ent_i.y[31], ent_i.y}) - $signed({qry_i.y[31], qry_i.y});
    r_sum   = {1'b0, qry_i.self_radius} + {1'b0, ent_i.radius};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= valid_i && band_ok;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_dx_q   <= dx_full[32:FRAC_BITS];
    a_dy_q   <= dy_full[32:FRAC_BITS];
    a_r_q    <= r_sum[16:1];
    a_nm_q   <= ent_i.no_mark;
    a_pass_q <= ent_i.passable;
    a_idx_q  <= idx_i;
  end

  // stage B: squares
  always_comb begin
    dx2 = a_dx_q * a_dx_q;
    dy2 = a_dy_q * a_dy_q;
    r2  = a_r_q * a_r_q;
  end

  always_ff @(posedge clk_i) begin
    b_dx2_q  <= dx2[40:0];
    b_dy2_q  <= dy2[40:0];
    b_r2_q   <= r2;
    b_nm_q   <= a_nm_q;
    b_pass_q <= a_pass_q;
    b_idx_q  <= a_idx_q;
  end

  // stage C: distance against radius
  always_comb begin
    hit_o.hit      = b_valid_q &&
                     (({1'b0, b_dx2_q} + {1'b0, b_dy2_q}) < {10'd0, b_r2_q});
    hit_o.no_mark  = b_nm_q;
    hit_o.passable = b_pass_q;
    hit_idx_o      = b_idx_q;
  end

endmodule

// ===== rtl/entity_overlap_query.sv =====
// ----------------------------------------------------------------------------
// entity_overlap_query
// Circle-overlap broad-phase collision against a ring of entity cells.
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o low; its result shows on
// res_o for exactly one cycle with done_o high and cannot be held off. Write,
// read, an unused function code and a query whose self entry is inactive or out
// of range give done_o in the cycle after acceptance. A real query rotates
// the entry ring once, one entry per cycle past a three-stage test unit, and
// busy_o stays high until its result is given.
module entity_overlap_query #(
  parameter int ENTITIES = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  eoq_pkg::eoq_req_t req_i,
  output logic              busy_o,
  output logic              done_o,
  output eoq_pkg::eoq_res_t res_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [5:0]        cfg_data_i
);
  import eoq_pkg::*;
  `include "entity_overlap_query_defines.svh"

  localparam int IDX_W = $clog2(ENTITIES);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTITIES - 1);

  eoq_state_e       state_q, state_d;
  logic [5:0]       count_q, player_q;
  logic [IDX_W-1:0] step_q;
  logic             drain_q;
  logic [IDX_W-1:0] self_q;
  logic             is_player_q;
  eoq_query_t       qry_q;
  logic             found_q, markr_q;
  logic [ENTITIES-1:0] mark_q;

  eoq_entry_t       ent [ENTITIES];
  eoq_entry_t       wr_ent, sel_ent;
  logic             accept, in_range, do_write, shift, elig;
  logic [IDX_W-1:0] sel;
  eoq_hit_t         hit;
  logic [IDX_W-1:0] hit_idx;

  assign accept   = start_i && (state_q == ST_IDLE);
  assign in_range = 32'(req_i.index) < 32'(ENTITIES);
  assign sel      = IDX_W'(req_i.index);
  assign do_write = accept && in_range && (eoq_func_e'(req_i.func) == FUNC_WRITE);
  assign shift    = (state_q == ST_WALK);
  assign sel_ent  = ent[sel];

  always_comb begin
    wr_ent.x        = req_i.pos_x;
    wr_ent.y        = req_i.pos_y;
    wr_ent.z        = req_i.pos_z;
    wr_ent.radius   = req_i.radius;
    wr_ent.active   = req_i.active;
    wr_ent.no_mark  = req_i.no_mark;
    wr_ent.passable = req_i.passable;
  end

  // entity ring: cell k takes from cell k+1, head wraps to the tail
  for (genvar k = 0; k < ENTITIES; k++) begin : g_cell
    eoq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .load_i       (do_write && (sel == IDX_W'(k))),
      .load_data_i  (wr_ent),
      .shift_i      (shift),
      .shift_data_i (ent[(k + 1) % ENTITIES]),
      .data_o       (ent[k])
    );
  end

  // head entry is eligible when below count, not self and active
  assign elig = shift && ent[0].active && (step_q != self_q) &&
                (32'(step_q) < 32'(count_q));

  eoq_test #(
    .IDX_W (IDX_W)
  ) u_test (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (elig),
    .idx_i     (step_q),
    .ent_i     (ent[0]),
    .qry_i     (qry_q),
    .hit_o     (hit),
    .hit_idx_o (hit_idx)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if ((eoq_func_e'(req_i.func) == FUNC_QUERY) && in_range && sel_ent.active) begin
            state_d = ST_WALK;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_WALK: begin
        if (step_q == LAST) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy_o    = (state_q != ST_IDLE);
    done_o    = (state_q == ST_DONE);
    res_o.found = found_q;
    res_o.mark  = markr_q;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      player_q <= 6'd32;
      step_q   <= '0;
      drain_q  <= 1'b0;
      found_q  <= 1'b0;
      markr_q  <= 1'b0;
      mark_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (eoq_reg_e'(cfg_idx_i))
          REG_ENTITY_COUNT: count_q  <= cfg_data_i;
          REG_PLAYER_INDEX: player_q <= cfg_data_i;
          default: ;
        endcase
      end
      step_q  <= (state_q == ST_WALK) ? step_q + 1'b1 : '0;
      drain_q <= (state_q == ST_DRAIN);
      if (accept) begin
        found_q <= 1'b0;
        markr_q <= (eoq_func_e'(req_i.func) == FUNC_READ) && in_range && mark_q[sel];
      end else if (hit.hit && !hit.passable) begin
        found_q <= 1'b1;
      end
      // marks: cleared by a write, set by a player hit
      if (do_write) begin
        mark_q[sel] <= 1'b0;
      end else if (hit.hit && is_player_q && !hit.no_mark) begin
        mark_q[hit_idx] <= 1'b1;
      end
    end
  end

  // query operands
  always_ff @(posedge clk_i) begin
    if (accept) begin
      qry_q.x           <= req_i.pos_x;
      qry_q.y           <= req_i.pos_y;
      qry_q.z           <= req_i.pos_z;
      qry_q.self_radius <= sel_ent.radius;
      self_q            <= sel;
      is_player_q       <= ({1'b0, req_i.index} == player_q);
    end
  end

  `EOQ_ASSERT_IMP(a_done_busy, done_o, busy_o, "done without busy")
  `EOQ_ASSERT_NXT(a_walk_end, (state_q == ST_WALK) && (step_q == LAST),
                  state_q == ST_DRAIN, "walk did not end after last entry")
  `EOQ_ASSERT_IMP(a_hit_phase, hit.hit,
                  (state_q == ST_WALK) || (state_q == ST_DRAIN), "hit outside walk")
  `EOQ_ASSERT_NXT(a_write_done, accept && (eoq_func_e'(req_i.func) == FUNC_WRITE),
                  done_o, "write did not complete next cycle")

endmodule

// ===== dv/entity_overlap_query_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// entity_overlap_query_chk
// Watches the request, result and register channels of the overlap block.
// It keeps its own copy of the entity table and the registers and works out
// each result when its request is taken. Every result is then compared with
// the oldest result still owed.
// ----------------------------------------------------------------------------
module entity_overlap_query_chk
  import eoq_pkg::*;
#(
  parameter int ENTITIES = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  eoq_req_t   req_i,
  input  logic       busy_o,
  input  logic       done_o,
  input  eoq_res_t   res_o,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [5:0] cfg_data_i,
  output int         fail_cnt_o,
  output int         owed_cnt_o,
  output int         hit_cnt_o,
  output int         mark_cnt_o
);

  // predicted table
  logic [31:0] tbl_x [ENTITIES];
  logic [31:0] tbl_y [ENTITIES];
  logic [31:0] tbl_z [ENTITIES];
  logic [15:0] tbl_rad [ENTITIES];
  logic        tbl_act [ENTITIES];
  logic        tbl_nomark [ENTITIES];
  logic        tbl_pass [ENTITIES];
  logic        tbl_mark [ENTITIES];
  logic [5:0]  walk_len;
  logic [5:0]  player;

  eoq_res_t owed_q[$];

  // overlap query against the predicted table, marks updated in place
  function automatic logic overlap_found(int self, logic [31:0] qx,
                                         logic [31:0] qy, logic [31:0] qz);
    longint dz, dx, dy, r, n;
    logic    hit_any;
    hit_any = 1'b0;
    if (self >= ENTITIES || !tbl_act[self]) return 1'b0;
    n = (walk_len > ENTITIES) ? ENTITIES : walk_len;
    for (int i = 0; i < n; i++) begin
      if (i == self || !tbl_act[i]) continue;
      dz = (longint'($signed(tbl_z[i])) >>> 12) - longint'($signed(qz));
      if (dz < Z_BAND_LO || dz > Z_BAND_HI) continue;
      dx = (longint'($signed(tbl_x[i])) - longint'($signed(qx))) >>> 12;
      dy = (longint'($signed(tbl_y[i])) - longint'($signed(qy))) >>> 12;
      r  = (longint'(tbl_rad[self]) + longint'(tbl_rad[i])) >>> 1;
      if (dx * dx + dy * dy >= r * r) continue;
      if (self == int'(player) && !tbl_nomark[i]) tbl_mark[i] = 1'b1;
      if (!tbl_pass[i]) hit_any = 1'b1;
    end
    return hit_any;
  endfunction

  // predict on request, compare on result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    eoq_res_t exp_res;
    if (!rst_ni) begin
      for (int i = 0; i < ENTITIES; i++) begin
        tbl_x[i] = '0; tbl_y[i] = '0; tbl_z[i] = '0; tbl_rad[i] = '0;
        tbl_act[i] = 1'b0; tbl_nomark[i] = 1'b0; tbl_pass[i] = 1'b0;
        tbl_mark[i] = 1'b0;
      end
      walk_len   <= '0;
      player     <= 6'd32;
      fail_cnt_o <= 0;
      hit_cnt_o  <= 0;
      mark_cnt_o <= 0;
      owed_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_ENTITY_COUNT) walk_len <= cfg_data_i;
        else player <= cfg_data_i;
      end
      if (start_i && !busy_o) begin
        exp_res = '0;
        case (req_i.func)
          FUNC_WRITE: begin
            tbl_x[req_i.index]      = req_i.pos_x;
            tbl_y[req_i.index]      = req_i.pos_y;
            tbl_z[req_i.index]      = req_i.pos_z;
            tbl_rad[req_i.index]    = req_i.radius;
            tbl_act[req_i.index]    = req_i.active;
            tbl_nomark[req_i.index] = req_i.no_mark;
            tbl_pass[req_i.index]   = req_i.passable;
            tbl_mark[req_i.index]   = 1'b0;
          end
          FUNC_QUERY: exp_res.found = overlap_found(int'(req_i.index), req_i.pos_x,
                                                    req_i.pos_y, req_i.pos_z);
          FUNC_READ: exp_res.mark = tbl_mark[req_i.index];
          default: ;
        endcase
        owed_q.push_back(exp_res);
      end
      if (done_o) begin
        if (owed_q.size() == 0) begin
          $display("%0t: result with nothing owed: actual found=%b mark=%b",
                   $time, res_o.found, res_o.mark);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          exp_res = owed_q.pop_front();
          if (res_o.found !== exp_res.found || res_o.mark !== exp_res.mark) begin
            $display("%0t: mismatch: expected found=%b mark=%b, actual found=%b mark=%b",
                     $time, exp_res.found, exp_res.mark, res_o.found, res_o.mark);
            fail_cnt_o <= fail_cnt_o + 1;
          end
          if (exp_res.found) hit_cnt_o <= hit_cnt_o + 1;
          if (exp_res.mark) mark_cnt_o <= mark_cnt_o + 1;
        end
      end
    end
  end

  assign owed_cnt_o = owed_q.size();

endmodule

// ===== dv/entity_overlap_query_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// entity_overlap_query_tb
// Drives the overlap block through several register settings. Each setting
// fills the table with clustered entities, then mixes queries aimed near
// them, mark reads, rewrites and random noise requests. The checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module entity_overlap_query_tb;
  import eoq_pkg::*;

  localparam int         ENTITIES  = 32;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  eoq_req_t   req = '0;
  logic       busy, done;
  eoq_res_t   res;
  logic       cfg_we = 1'b0;
  logic       cfg_idx = REG_ENTITY_COUNT;
  logic [5:0] cfg_data = '0;
  int         fails, owed, hits, marks;

  // shadow of written positions, used only to aim requests and skip unwritten reads
  logic        written [ENTITIES];
  logic [31:0] wz [ENTITIES];
  logic [31:0] wx [ENTITIES];
  logic [31:0] wy [ENTITIES];
  logic [31:0] ctr_x, ctr_y;
  int          n_req;
  logic        calm;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  entity_overlap_query #(.ENTITIES(ENTITIES)) dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .req_i(req), .busy_o(busy),
    .done_o(done), .res_o(res), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data)
  );

  entity_overlap_query_chk #(.ENTITIES(ENTITIES)) chk (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .req_i(req), .busy_o(busy),
    .done_o(done), .res_o(res), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data), .fail_cnt_o(fails), .owed_cnt_o(owed),
    .hit_cnt_o(hits), .mark_cnt_o(marks)
  );

  // hand one request over and wait until it is taken
  task automatic send_req(eoq_req_t r);
    int gap;
    if (!calm && $urandom_range(3) == 0) begin
      gap = $urandom_range(16, 1);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (r.func == FUNC_WRITE) begin
      written[r.index] = 1'b1;
      wx[r.index] = r.pos_x; wy[r.index] = r.pos_y; wz[r.index] = r.pos_z;
    end
    start <= 1'b1;
    req   <= r;
    do @(negedge clk); while (busy);
    @(posedge clk);
    n_req++;
  endtask

  // quiet the request side and let every owed result arrive
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(eoq_reg_e idx, logic [5:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // entity near the current cluster center
  function automatic eoq_req_t near_entity(int idx);
    eoq_req_t r;
    r          = '0;
    r.func     = FUNC_WRITE;
    r.index    = 5'(idx);
    r.pos_x    = ctr_x + $signed($urandom_range(1 << 19)) - (1 << 18);
    r.pos_y    = ctr_y + $signed($urandom_range(1 << 19)) - (1 << 18);
    r.pos_z    = (($urandom_range(400) - 200) << 12) + $urandom_range(4095);
    r.radius   = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(160));
    r.active   = ($urandom_range(5) != 0);
    r.no_mark  = 1'($urandom_range(1));
    r.passable = ($urandom_range(3) == 0);
    return r;
  endfunction

  // query from a random entry, aimed at the z band of a randomly picked entry if written
  function automatic eoq_req_t aimed_query();
    eoq_req_t r;
    int       self, tgt;
    r      = '0;
    r.func = FUNC_QUERY;
    self   = $urandom_range(ENTITIES - 1);
    tgt    = $urandom_range(ENTITIES - 1);
    r.index = 5'(self);
    if (written[self] && $urandom_range(1)) begin
      r.pos_x = wx[self];
      r.pos_y = wy[self];
    end else begin
      r.pos_x = ctr_x + $signed($urandom_range(1 << 19)) - (1 << 18);
      r.pos_y = ctr_y + $signed($urandom_range(1 << 19)) - (1 << 18);
    end
    if (written[tgt])
      r.pos_z = ($signed(wz[tgt]) >>> 12) + $signed($urandom_range(300)) - 150;
    else
      r.pos_z = $signed($urandom_range(400)) - 200;
    return r;
  endfunction

  function automatic eoq_req_t noise_req();
    eoq_req_t r;
    r = $bits(eoq_req_t)'({$urandom, $urandom, $urandom, $urandom});
    if (r.func == FUNC_READ && !written[r.index]) r.func = FUNC_NONE;
    return r;
  endfunction

  // one register setting: fill, then mixed traffic
  task automatic phase(logic [5:0] cnt, logic [5:0] plr, int n_items);
    eoq_req_t r;
    int       k, pick;
    write_reg(REG_ENTITY_COUNT, cnt);
    write_reg(REG_PLAYER_INDEX, plr);
    ctr_x = $urandom;
    ctr_y = $urandom;
    for (int i = 0; i < ENTITIES; i++) begin
      if ($urandom_range(7) != 0) send_req(near_entity(i));
    end
    for (k = 0; k < n_items; k++) begin
      pick = $urandom_range(19);
      if (pick < 10) begin
        r = aimed_query();
        if ($urandom_range(3) == 0 && plr < ENTITIES) r.index = 5'(plr);
      end else if (pick < 14) begin
        r = '0;
        r.func  = FUNC_READ;
        r.index = 5'($urandom_range(ENTITIES - 1));
        if (!written[r.index]) r.func = FUNC_NONE;
      end else if (pick < 17) begin
        r = near_entity($urandom_range(ENTITIES - 1));
      end else begin
        r = noise_req();
      end
      send_req(r);
    end
    drain();
  endtask

  // directed corners: field extremes, every function, inactive self
  task automatic directed();
    eoq_req_t r;
    r = '0;
    r.func = FUNC_QUERY; r.index = 5'd0;
    send_req(r);
    r = '0;
    r.func = FUNC_WRITE; r.index = 5'd0; r.pos_x = 32'h7FFF_FFFF; r.pos_y = 32'h7FFF_FFFF;
    r.pos_z = 32'h0000_0FFF; r.radius = 16'hFFFF; r.active = 1'b1;
    send_req(r);
    r.index = 5'd1; r.pos_x = 32'h8000_0000; r.pos_y = 32'h8000_0000;
    r.pos_z = 32'hFFFF_F000; r.no_mark = 1'b0; r.passable = 1'b0;
    send_req(r);
    r.index = 5'd31; r.pos_x = 32'h7FFF_F000; r.pos_y = 32'h7FFF_F000; r.pos_z = '0;
    r.radius = 16'hFFFF; r.no_mark = 1'b1; r.passable = 1'b1;
    send_req(r);
    r.index = 5'd2; r.pos_x = '0; r.pos_y = '0; r.pos_z = 32'(127 << 12);
    r.radius = 16'd0; r.no_mark = 1'b0; r.passable = 1'b0;
    send_req(r);
    r.index = 5'd3; r.pos_z = 32'(-126 << 12); r.radius = 16'd2;
    send_req(r);
    r.index = 5'd4; r.pos_z = 32'(128 << 12); r.radius = 16'd2000;
    send_req(r);
    r.index = 5'd5; r.active = 1'b0;
    send_req(r);
    // queries from extremes and from the origin entries
    r = '0; r.func = FUNC_QUERY;
    r.index = 5'd0; r.pos_x = 32'h8000_0000; r.pos_y = 32'h8000_0000; r.pos_z = 32'h8000_0000;
    send_req(r);
    r.index = 5'd1; r.pos_x = 32'h7FFF_FFFF; r.pos_y = 32'h7FFF_FFFF; r.pos_z = 32'h7FFF_FFFF;
    send_req(r);
    r.index = 5'd31; r.pos_x = 32'h7FFF_F000; r.pos_y = 32'h7FFF_F000; r.pos_z = '0;
    send_req(r);
    r.index = 5'd2; r.pos_x = '0; r.pos_y = '0; r.pos_z = '0;
    send_req(r);
    r.index = 5'd3; r.pos_z = 32'hFFFF_FFFF;
    send_req(r);
    r.index = 5'd5;
    send_req(r);
    r.index = 5'd6;
    send_req(r);
    for (int i = 0; i < 6; i++) begin
      r = '0; r.func = FUNC_READ; r.index = 5'(i);
      send_req(r);
    end
    r = '0; r.func = FUNC_NONE; r.index = 5'd31; r.pos_x = 32'hFFFF_FFFF;
    send_req(r);
    r.func = FUNC_READ; r.index = 5'd31;
    send_req(r);
    drain();
  endtask

  // stimulus
  initial begin
    for (int i = 0; i < ENTITIES; i++) written[i] = 1'b0;
    n_req = 0;
    calm  = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_reg(REG_ENTITY_COUNT, 6'd32);
    write_reg(REG_PLAYER_INDEX, 6'd2);
    directed();
    phase(6'd32, 6'd0, 80);
    phase(6'd0, 6'd32, 20);
    phase(6'd63, 6'd31, 60);
    phase(6'($urandom_range(31, 1)), 6'($urandom_range(31)), 60);
    phase(6'd32, 6'd63, 50);
    phase(6'd32, 6'($urandom_range(31)), 60);
    calm = 1'b1;
    phase(6'd32, 6'($urandom_range(31)), 40);
    drain();
    repeat (ENTITIES + 8) @(posedge clk);
    $display("Sent %0d requests over seven register settings.", n_req);
    $display("Results with found set: %0d, mark reads set: %0d.", hits, marks);
    if (fails == 0 && owed == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
